FILE: rtl/bst_pkg.sv
// bst_pkg: shared types and constants for the bounded set table.
// Holds the command opcodes, the command and result transaction structs
// and the default capacity. No dependencies.
`timescale 1ns / 1ps

package bst_pkg;

   localparam int BST_CAPACITY = 64;
   localparam int VALUE_W      = 32;
   localparam int RES_COUNT_W  = 7;

   typedef enum logic [1:0] {
      OP_QUERY  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } bst_op_type;

   typedef struct packed {
      bst_op_type                 opcode;
      logic signed [VALUE_W-1:0]  value;
   } bst_cmd_type;

   typedef struct packed {
      logic                    status;
      logic                    is_member;
      logic [RES_COUNT_W-1:0]  count_greater;
      logic [RES_COUNT_W-1:0]  count_less;
      logic [RES_COUNT_W-1:0]  set_size;
      logic                    is_empty;
   } bst_result_type;

endpackage

FILE: rtl/bounded_set_table.sv
// bounded_set_table: top level of the bounded set table.
// Holds the request handshake and the response output register around bst_engine.
// Depends on bst_pkg and bst_engine.
`timescale 1ns / 1ps

// The block keeps a set of distinct signed 32-bit values, up to CAPACITY of
// them, in one single-port-read, single-port-write RAM, plus an element count
// that reset clears. Each request transaction carries an opcode (query,
// insert, delete, clear) and a value; each yields exactly one response
// transaction with status, membership and the greater and less counts taken
// over the set before the command, and the size and empty flag after it.
// Commands run one at a time: an accepted command starts the scan, reads
// the n stored elements one RAM read a cycle, decides, then for a
// successful delete shifts each element above the removed one down by a
// read and a write per cycle, and hands the result to the output register
// once that register is free. req_stall is high while a command is in
// progress; a finished response waits in the output register without
// holding up the start of the next command. No clearing pass is needed
// after reset: only entries below the count are ever read.

module bounded_set_table #(
   parameter int CAPACITY = bst_pkg::BST_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic signed [bst_pkg::VALUE_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_status,
   output logic                                  rsp_is_member,
   output logic [bst_pkg::RES_COUNT_W-1:0]       rsp_count_greater,
   output logic [bst_pkg::RES_COUNT_W-1:0]       rsp_count_less,
   output logic [bst_pkg::RES_COUNT_W-1:0]       rsp_set_size,
   output logic                                  rsp_is_empty
);

   import bst_pkg::*;

   logic           engine_idle;
   logic           start;
   bst_cmd_type    cmd;
   logic           out_free;
   logic           res_valid;
   bst_result_type result;

   logic           rsp_valid_ff, rsp_valid_in;
   bst_result_type rsp_ff, rsp_in;

   // Take a request transaction only while the sequencer is idle.
   assign req_stall  = !engine_idle;
   assign start      = req_valid && !req_stall;
   assign cmd.opcode = bst_op_type'(req_opcode);
   assign cmd.value  = req_value;

   // The output register is free when empty or emptied at this edge.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   bst_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .out_free  (out_free),
      .idle      (engine_idle),
      .res_valid (res_valid),
      .result    (result)
   );

   // Load a finished result; drop the valid once the transaction completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_is_member     = rsp_ff.is_member;
   assign rsp_count_greater = rsp_ff.count_greater;
   assign rsp_count_less    = rsp_ff.count_less;
   assign rsp_set_size      = rsp_ff.set_size;
   assign rsp_is_empty      = rsp_ff.is_empty;

endmodule

FILE: rtl/bst_ram.sv
// bst_ram: generic single-clock RAM, one write port and one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bst_engine.sv
// bst_engine: command sequencer of the bounded set table around the element RAM.
// Scans the stored elements, decides the command and shifts entries down on delete.
// Depends on bst_pkg and bst_ram.
`timescale 1ns / 1ps

module bst_engine #(
   parameter int CAPACITY = bst_pkg::BST_CAPACITY
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  bst_pkg::bst_cmd_type    cmd,
   input  logic                    out_free,
   output logic                    idle,
   output logic                    res_valid,
   output bst_pkg::bst_result_type result
);

   import bst_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          chk_ff, chk_in;
   logic [IDX_W-1:0]          hit_ff, hit_in;
   logic [IDX_W-1:0]          shift_ff, shift_in;
   bst_op_type                op_ff, op_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      member_ff, member_in;
   logic [CNT_W-1:0]          greater_ff, greater_in;
   logic [CNT_W-1:0]          less_ff, less_in;
   bst_result_type            result_ff, result_in;
   logic                      res_valid_ff, res_valid_in;

   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic [VALUE_W-1:0]        rd_data;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [VALUE_W-1:0]        wr_data;

   logic                      scan_last;
   logic                      shift_more;
   logic [CNT_W-1:0]          new_count;
   logic                      fail;

   bst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      chk_in       = chk_ff;
      hit_in       = hit_ff;
      shift_in     = shift_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      member_in    = member_ff;
      greater_in   = greater_ff;
      less_in      = less_ff;
      result_in    = result_ff;
      res_valid_in = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = value_ff;
      new_count    = count_ff;
      fail         = 1'b0;
      scan_last    = (CNT_W'(chk_ff) + CNT_W'(1)) == count_ff;
      shift_more   = (CNT_W'(shift_ff) + CNT_W'(1)) < count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = cmd.opcode;
               value_in   = cmd.value;
               member_in  = 1'b0;
               greater_in = '0;
               less_in    = '0;
               hit_in     = '0;
               chk_in     = '0;
               if (count_ff != '0) begin
                  rd_en    = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_SCAN: begin
            // rd_data holds entry chk_ff
            if (rd_data == value_ff) begin
               if (!member_ff) begin
                  hit_in = chk_ff;
               end
               member_in = 1'b1;
            end else if ($signed(rd_data) > value_ff) begin
               greater_in = greater_ff + CNT_W'(1);
            end else begin
               less_in = less_ff + CNT_W'(1);
            end
            if (scan_last) begin
               state_in = ST_DECIDE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = chk_ff + IDX_W'(1);
               chk_in  = chk_ff + IDX_W'(1);
            end
         end

         ST_DECIDE: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_QUERY: begin
               end
               OP_INSERT: begin
                  if (member_ff || (count_ff >= CNT_W'(CAPACITY))) begin
                     fail = 1'b1;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = IDX_W'(count_ff);
                     new_count = count_ff + CNT_W'(1);
                  end
               end
               OP_DELETE: begin
                  if (!member_ff) begin
                     fail = 1'b1;
                  end else begin
                     new_count = count_ff - CNT_W'(1);
                     // later entries exist: pull the first one up
                     if (CNT_W'(hit_ff) < new_count) begin
                        rd_en    = 1'b1;
                        rd_addr  = hit_ff + IDX_W'(1);
                        shift_in = hit_ff;
                        state_in = ST_SHIFT;
                     end
                  end
               end
               OP_CLEAR: begin
                  new_count = '0;
               end
               default: begin
               end
            endcase
            count_in                = new_count;
            result_in.status        = fail;
            result_in.is_member     = member_ff;
            result_in.count_greater = RES_COUNT_W'(greater_ff);
            result_in.count_less    = RES_COUNT_W'(less_ff);
            result_in.set_size      = RES_COUNT_W'(new_count);
            result_in.is_empty      = (new_count == '0);
         end

         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = shift_ff;
            wr_data = rd_data;
            if (shift_more) begin
               rd_en    = 1'b1;
               rd_addr  = shift_ff + IDX_W'(2);
               shift_in = shift_ff + IDX_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               res_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
      chk_ff     <= chk_in;
      hit_ff     <= hit_in;
      shift_ff   <= shift_in;
      op_ff      <= op_in;
      value_ff   <= value_in;
      member_ff  <= member_in;
      greater_ff <= greater_in;
      less_ff    <= less_in;
      result_ff  <= result_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = res_valid_ff;
   assign result    = result_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of the same entry in one cycle");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0))
      else $error("scan running over an empty set");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE))
      else $error("command started while busy");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> ($past(state_ff) == ST_DONE))
      else $error("result issued outside the done step");
`endif

endmodule
